// ===== rtl/rbu_pkg.sv =====
// ----------------------------------------------------------------------------
// rbu_pkg: shared types and helpers for the RGB888 blend unit
// Holds the action codes, the beat structs of both channels, the struct that
// passes per-channel products between the stages, and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package rbu_pkg;

	localparam int unsigned ChanW  = 8;
	localparam int unsigned NumCh  = 3;
	localparam int unsigned ColorW = ChanW * NumCh;
	localparam int unsigned ProdW  = 2 * ChanW;

	localparam logic [ChanW-1:0] ChanFull = 8'hFF;
	localparam logic [ChanW-1:0] LumaR    = 8'd54;
	localparam logic [ChanW-1:0] LumaG    = 8'd183;
	localparam logic [ChanW-1:0] LumaB    = 8'd19;

	typedef enum logic [1:0] {
		ACT_WHITE     = 2'd0,
		ACT_BLACK     = 2'd1,
		ACT_HIGHLIGHT = 2'd2,
		ACT_MIX       = 2'd3
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [ColorW-1:0] primary_color;
		logic [ColorW-1:0] secondary_color;
		logic [ChanW-1:0]  blend_amount;
	} item_t;

	typedef struct packed {
		logic [ColorW-1:0] result_color;
		logic              went_lighter;
	} result_t;

	// Two weighted terms per channel; their sum divided by 255 is the channel.
	typedef struct packed {
		logic                        valid;
		logic [NumCh-1:0][ProdW-1:0] term_u;
		logic [NumCh-1:0][ProdW-1:0] term_v;
		logic                        went_lighter;
	} prod_t;

	// Truncating x / 255 for x up to 255 * 255: (x + (x >> 8) + 1) >> 8.
	function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW:0] acc;
		acc = {1'b0, x} + {{(ChanW+1){1'b0}}, x[ProdW-1:ChanW]} + {{ProdW{1'b0}}, 1'b1};
		return acc[ProdW-1:ChanW];
	endfunction

endpackage

// ===== rtl/rbu_mult_stage.sv =====
// ----------------------------------------------------------------------------
// rbu_mult_stage: luma decision and per-channel weighting products
// Every action is written as (u * (255 - a) + v) / 255 per channel; this stage
// forms both terms from the registered input beat and registers them.
// ----------------------------------------------------------------------------
module rbu_mult_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  rbu_pkg::item_t item_s1,
	output rbu_pkg::prod_t prod_s2
);

	logic [rbu_pkg::ChanW-1:0]                     amt;
	logic [rbu_pkg::ChanW-1:0]                     namt;
	logic [rbu_pkg::ProdW-1:0]                     luma_sum;
	logic                                          is_dark;
	logic                                          to_white;
	logic [rbu_pkg::ProdW-1:0]                     white_term;
	logic [rbu_pkg::NumCh-1:0][rbu_pkg::ChanW-1:0] prim_ch;
	logic [rbu_pkg::NumCh-1:0][rbu_pkg::ChanW-1:0] sec_ch;
	rbu_pkg::prod_t                                prod_d;
	logic                                          valid_s2;
	rbu_pkg::prod_t                                data_s2;

	assign amt  = item_s1.blend_amount;
	assign namt = rbu_pkg::ChanFull - amt;
	assign prim_ch = item_s1.primary_color;
	assign sec_ch  = item_s1.secondary_color;

	// Channel 2 is red, channel 0 is blue.
	assign luma_sum = rbu_pkg::ProdW'(prim_ch[2] * rbu_pkg::LumaR)
		+ rbu_pkg::ProdW'(prim_ch[1] * rbu_pkg::LumaG)
		+ rbu_pkg::ProdW'(prim_ch[0] * rbu_pkg::LumaB);

	// Luma below 128 means the top bit of the unshifted sum is clear.
	assign is_dark = ~luma_sum[rbu_pkg::ProdW-1];

	always_comb begin
		unique case (item_s1.action)
			rbu_pkg::ACT_WHITE:     to_white = 1'b1;
			rbu_pkg::ACT_BLACK:     to_white = 1'b0;
			rbu_pkg::ACT_HIGHLIGHT: to_white = is_dark;
			default:                to_white = 1'b0;
		endcase
	end

	// 255 * a, the added term when blending toward white.
	assign white_term = {amt, {rbu_pkg::ChanW{1'b0}}} - {{rbu_pkg::ChanW{1'b0}}, amt};

	always_comb begin
		prod_d.valid        = valid_s1;
		prod_d.went_lighter = (item_s1.action == rbu_pkg::ACT_HIGHLIGHT) && is_dark;
		for (int c = 0; c < rbu_pkg::NumCh; c++) begin
			if (item_s1.action == rbu_pkg::ACT_MIX) begin
				prod_d.term_u[c] = rbu_pkg::ProdW'(sec_ch[c] * namt);
				prod_d.term_v[c] = rbu_pkg::ProdW'(prim_ch[c] * amt);
			end else begin
				prod_d.term_u[c] = rbu_pkg::ProdW'(prim_ch[c] * namt);
				prod_d.term_v[c] = to_white ? white_term : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= prod_d;
	end

	always_comb begin
		prod_s2       = data_s2;
		prod_s2.valid = valid_s2;
	end

endmodule

// ===== rtl/rbu_div_stage.sv =====
// ----------------------------------------------------------------------------
// rbu_div_stage: term sum, divide by 255 and result register
// Adds the two registered terms of each channel, divides by 255 with a shift
// and add, packs the colour and registers the result beat with its strobe.
// ----------------------------------------------------------------------------
module rbu_div_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  rbu_pkg::prod_t   prod_s2,
	output logic             done,
	output rbu_pkg::result_t result
);

	logic [rbu_pkg::NumCh-1:0][rbu_pkg::ChanW-1:0] chan_d;
	rbu_pkg::result_t                              result_d;
	logic                                          done_q;
	rbu_pkg::result_t                              result_q;

	// The two terms never sum past 255 * 255, so 16 bits hold the sum.
	always_comb begin
		for (int c = 0; c < rbu_pkg::NumCh; c++) begin
			chan_d[c] = rbu_pkg::div255(prod_s2.term_u[c] + prod_s2.term_v[c]);
		end
		result_d.result_color = chan_d;
		result_d.went_lighter = prod_s2.went_lighter;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= prod_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/rgb_blend_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_blend_unit: per-pixel RGB888 blend toward white, black, by luma, or mix
//
//   channel   ports                        handshake
//   -------   --------------------------   ---------------------------------
//   item      start, busy, item            beat taken when start && !busy
//   result    done, result                 beat valid for one cycle on done
//
// One beat is taken every cycle; busy is always low.
// Each result passes from start to done through the input register,
// the product register (one 8x8 multiply per term) and the result register.
// Reset clears only the strobe pipeline; no beat is in flight after it.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module rgb_blend_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rbu_pkg::item_t   item,
	output logic             done,
	output rbu_pkg::result_t result
);

	logic           valid_s1;
	rbu_pkg::item_t item_s1;
	rbu_pkg::prod_t prod_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	rbu_mult_stage u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.prod_s2  (prod_s2)
	);

	rbu_div_stage u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.prod_s2 (prod_s2),
		.done    (done),
		.result  (result)
	);

	// Every accepted beat comes out on done, and done pulses for no other beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("accepted beat produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result strobe without an accepted beat");

	// The lighter flag only comes from a highlight beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.went_lighter) |-> ($past(item.action, 3) == rbu_pkg::ACT_HIGHLIGHT))
		else $error("went_lighter set for a non-highlight beat");

	// Blending toward white never darkens the red channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.went_lighter) |->
		(result.result_color[23:16] >= $past(item.primary_color[23:16], 3)))
		else $error("highlight toward white darkened a channel");

endmodule
